### design/bopf_pkg.sv
// Shared types, sizes and helpers for the box overlap pair finder.
// No dependencies; the top level refers to it by scoped names.
package bopf_pkg;

    localparam int LIST_DEPTH  = 16;
    localparam int MAX_RESULTS = 16;

    localparam int IDX_W   = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int CNT_W   = $clog2(LIST_DEPTH + 1);
    localparam int FOUND_W = $clog2(MAX_RESULTS + 1);
    localparam int HIT_W   = 4;
    localparam int EXT_W   = 33;

    localparam logic [1:0] FUNC_CLEAR  = 2'd0;
    localparam logic [1:0] FUNC_APPEND = 2'd1;
    localparam logic [1:0] FUNC_QUERY  = 2'd2;

    typedef logic signed [EXT_W-1:0] ext_t;

    // Four absolute box extents, formed at full width.
    typedef struct packed {
        ext_t left_x;
        ext_t right_x;
        ext_t top_y;
        ext_t bottom_y;
    } box_t;

    function automatic box_t make_box(
        input logic signed [31:0] px,
        input logic signed [31:0] py,
        input logic signed [15:0] el,
        input logic signed [15:0] er,
        input logic signed [15:0] et,
        input logic signed [15:0] eb
    );
        box_t b;
        b.left_x   = ext_t'(px) + ext_t'(el);
        b.right_x  = ext_t'(px) + ext_t'(er);
        b.top_y    = ext_t'(py) + ext_t'(et);
        b.bottom_y = ext_t'(py) + ext_t'(eb);
        return b;
    endfunction

    // Touching edges count as overlap.
    function automatic logic boxes_overlap(input box_t q, input box_t e);
        return !((q.left_x > e.right_x) || (q.right_x < e.left_x) ||
                 (q.top_y > e.bottom_y) || (q.bottom_y < e.top_y));
    endfunction

    function automatic logic [HIT_W-1:0] to_hit_index(input logic [CNT_W-1:0] i);
        logic [CNT_W+HIT_W-1:0] wide;
        wide = {{HIT_W{1'b0}}, i};
        return wide[HIT_W-1:0];
    endfunction

endpackage

### design/box_overlap_pair_finder_top.sv
// Box overlap pair finder: entry store, scan sequencer and result register.
// Depends on bopf_pkg for sizes, function codes and the box helpers.
//
// A user loads a list of up to 16 boxes with append words (func 1), empties it
// with a clear word (func 0) and sends query words (func 2). Clear and append
// produce no result; an append into a full list is dropped, and a func code of
// 3 is ignored. Each stored box keeps its four absolute edges, formed at 33 bits
// when appended, so a query only compares. A live query is accepted, then scans
// one stored entry per cycle through the single shared edge comparator, stalling
// only while a held hit waits for the result side, then detects the end of the
// list and hands over its final result. A query that is not live skips the
// scan. s_ready is high only while the sequencer is idle.
// Every live stored entry whose box overlaps a live query box gives one result
// word carrying its index with hit_valid set, in load order; the last word of a
// query has m_last set. A query that is not live, or hits nothing, gives one
// word with hit_valid clear, index zero and m_last set. One hit is held back in
// a pending register so that m_last can be attached once the scan ends.
module box_overlap_pair_finder_top (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [1:0]                    s_func,
    input  logic signed [31:0]            s_pos_x,
    input  logic signed [31:0]            s_pos_y,
    input  logic signed [15:0]            s_edge_left,
    input  logic signed [15:0]            s_edge_right,
    input  logic signed [15:0]            s_edge_top,
    input  logic signed [15:0]            s_edge_bottom,
    input  logic signed [15:0]            s_health,
    input  logic                          s_is_active,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [bopf_pkg::HIT_W-1:0]    m_hit_index,
    output logic                          m_hit_valid,
    output logic                          m_last
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_FLUSH = 2'd2;

    // Entry store: written on append, read at the scan index.
    bopf_pkg::box_t entry_box_reg  [bopf_pkg::LIST_DEPTH];
    logic           entry_live_reg [bopf_pkg::LIST_DEPTH];

    logic [1:0]                   state_reg, state_next;
    logic [bopf_pkg::CNT_W-1:0]   count_reg, count_next;
    logic [bopf_pkg::CNT_W-1:0]   idx_reg, idx_next;
    logic [bopf_pkg::FOUND_W-1:0] found_reg, found_next;
    bopf_pkg::box_t               query_reg;
    logic                         pend_valid_reg, pend_valid_next;
    logic [bopf_pkg::CNT_W-1:0]   pend_idx_reg, pend_idx_next;

    logic                         out_valid_reg;
    logic [bopf_pkg::HIT_W-1:0]   out_index_reg;
    logic                         out_hit_reg;
    logic                         out_last_reg;

    logic                         accept;
    logic                         in_live;
    bopf_pkg::box_t               in_box;
    logic                         append_ok;
    logic                         out_free;
    logic                         scan_hit;
    logic                         out_load;
    logic [bopf_pkg::HIT_W-1:0]   out_index_d;
    logic                         out_hit_d;
    logic                         out_last_d;

    assign s_ready  = (state_reg == ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign in_live  = (s_health > 16'sd0) && s_is_active;
    assign in_box   = bopf_pkg::make_box(s_pos_x, s_pos_y, s_edge_left, s_edge_right,
                                         s_edge_top, s_edge_bottom);
    assign append_ok = accept && (s_func == bopf_pkg::FUNC_APPEND) &&
                       (count_reg < bopf_pkg::CNT_W'(bopf_pkg::LIST_DEPTH));
    assign out_free = !out_valid_reg || m_ready;

    // Shared comparator: stored box at the scan index against the query box.
    assign scan_hit = entry_live_reg[idx_reg[bopf_pkg::IDX_W-1:0]] &&
                      bopf_pkg::boxes_overlap(query_reg,
                                              entry_box_reg[idx_reg[bopf_pkg::IDX_W-1:0]]);

    // Sequencer: idle -> scan (live queries only), one entry per cycle unless stalled -> final word.
    always_comb begin
        state_next      = state_reg;
        count_next      = count_reg;
        idx_next        = idx_reg;
        found_next      = found_reg;
        pend_valid_next = pend_valid_reg;
        pend_idx_next   = pend_idx_reg;
        out_load        = 1'b0;
        out_index_d     = '0;
        out_hit_d       = 1'b0;
        out_last_d      = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    case (s_func)
                        bopf_pkg::FUNC_CLEAR: begin
                            count_next = '0;
                        end
                        bopf_pkg::FUNC_APPEND: begin
                            if (append_ok) begin
                                count_next = count_reg + 1'b1;
                            end
                        end
                        bopf_pkg::FUNC_QUERY: begin
                            idx_next        = '0;
                            found_next      = '0;
                            pend_valid_next = 1'b0;
                            state_next      = in_live ? ST_SCAN : ST_FLUSH;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                if ((idx_reg == count_reg) ||
                    (found_reg == bopf_pkg::FOUND_W'(bopf_pkg::MAX_RESULTS))) begin
                    state_next = ST_FLUSH;
                end else if (scan_hit && pend_valid_reg) begin
                    // Release the held hit, which is not the last one.
                    if (out_free) begin
                        out_load      = 1'b1;
                        out_index_d   = bopf_pkg::to_hit_index(pend_idx_reg);
                        out_hit_d     = 1'b1;
                        pend_idx_next = idx_reg;
                        found_next    = found_reg + 1'b1;
                        idx_next      = idx_reg + 1'b1;
                    end
                end else if (scan_hit) begin
                    pend_valid_next = 1'b1;
                    pend_idx_next   = idx_reg;
                    found_next      = found_reg + 1'b1;
                    idx_next        = idx_reg + 1'b1;
                end else begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_FLUSH: begin
                if (out_free) begin
                    out_load        = 1'b1;
                    out_index_d     = pend_valid_reg ?
                                      bopf_pkg::to_hit_index(pend_idx_reg) : '0;
                    out_hit_d       = pend_valid_reg;
                    out_last_d      = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            count_reg      <= '0;
            idx_reg        <= '0;
            found_reg      <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            idx_reg        <= idx_next;
            found_reg      <= found_next;
            pend_valid_reg <= pend_valid_next;
            if (out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers: no reset needed.
    always_ff @(posedge aclk) begin
        pend_idx_reg <= pend_idx_next;
        if (accept && (s_func == bopf_pkg::FUNC_QUERY)) begin
            query_reg <= in_box;
        end
        if (append_ok) begin
            entry_box_reg[count_reg[bopf_pkg::IDX_W-1:0]]  <= in_box;
            entry_live_reg[count_reg[bopf_pkg::IDX_W-1:0]] <= in_live;
        end
        if (out_load) begin
            out_index_reg <= out_index_d;
            out_hit_reg   <= out_hit_d;
            out_last_reg  <= out_last_d;
        end
    end

    assign m_valid     = out_valid_reg;
    assign m_hit_index = out_index_reg;
    assign m_hit_valid = out_hit_reg;
    assign m_last      = out_last_reg;

`ifndef SYNTHESIS
    a_count_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= bopf_pkg::CNT_W'(bopf_pkg::LIST_DEPTH))
        else $error("entry count exceeds list depth");

    a_append_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        append_ok |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("append did not advance entry count");

    a_nohit_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_hit_valid) |-> m_last)
        else $error("no-hit word without last");

    a_scan_index_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN) |-> (idx_reg <= count_reg))
        else $error("scan index past entry count");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |-> !out_load)
        else $error("result word overwritten while stalled");
`endif

endmodule

### tb/sv/tb.sv
// Self-checking testbench for box_overlap_pair_finder_top: directed table, then random
// clear/append/query sequences, checked against typed results or an overlap predictor.
// Depends on bopf_pkg for sizes and function codes; needs nothing beyond the RTL.
`timescale 1ns / 100ps

module tb;

    // Selector three is not a function of the block; words carrying it are ignored.
    localparam logic [1:0] FUNC_IGNORED = 2'd3;

    localparam int RANDOM_WORDS = 375;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 64;

    typedef struct {
        logic [1:0]         func;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [15:0] edge_left;
        logic signed [15:0] edge_right;
        logic signed [15:0] edge_top;
        logic signed [15:0] edge_bottom;
        logic signed [15:0] health;
        logic               is_active;
    } box_word_t;

    typedef struct {
        logic [bopf_pkg::HIT_W-1:0] hit_index;
        logic                       hit_valid;
        logic                       last;
    } hit_word_t;

    // A table row either trusts the predictor or carries its result typed in.
    typedef enum logic { CHECK_MODEL, CHECK_TYPED } check_kind_t;

    typedef struct {
        box_word_t   w;
        check_kind_t kind;
        hit_word_t   typed;
    } stim_row_t;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    logic                       s_valid       = 1'b0;
    logic                       s_ready;
    logic [1:0]                 s_func        = bopf_pkg::FUNC_CLEAR;
    logic signed [31:0]         s_pos_x       = '0;
    logic signed [31:0]         s_pos_y       = '0;
    logic signed [15:0]         s_edge_left   = '0;
    logic signed [15:0]         s_edge_right  = '0;
    logic signed [15:0]         s_edge_top    = '0;
    logic signed [15:0]         s_edge_bottom = '0;
    logic signed [15:0]         s_health      = '0;
    logic                       s_is_active   = 1'b0;
    logic                       m_valid;
    logic                       m_ready       = 1'b0;
    logic [bopf_pkg::HIT_W-1:0] m_hit_index;
    logic                       m_hit_valid;
    logic                       m_last;

    int error_count   = 0;
    int send_idle_pct = 23;
    int recv_idle_pct = 47;

    // Predicted hit words, oldest first.
    hit_word_t expected_hits_q[$];
    stim_row_t directed_rows[$];

    // Shadow of the entry store: absolute edges at full width and the live mark.
    longint store_left[bopf_pkg::LIST_DEPTH];
    longint store_right[bopf_pkg::LIST_DEPTH];
    longint store_top[bopf_pkg::LIST_DEPTH];
    longint store_bottom[bopf_pkg::LIST_DEPTH];
    bit     store_live[bopf_pkg::LIST_DEPTH];
    int     store_count = 0;

    box_overlap_pair_finder_top i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_func        (s_func),
        .s_pos_x       (s_pos_x),
        .s_pos_y       (s_pos_y),
        .s_edge_left   (s_edge_left),
        .s_edge_right  (s_edge_right),
        .s_edge_top    (s_edge_top),
        .s_edge_bottom (s_edge_bottom),
        .s_health      (s_health),
        .s_is_active   (s_is_active),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_hit_index   (m_hit_index),
        .m_hit_valid   (m_hit_valid),
        .m_last        (m_last)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    // Update the shadow store for one accepted word and queue the hit words it causes.
    // Edges are summed as 64-bit signed values, so nothing wraps.
    function automatic void predict_overlaps(input box_word_t w);
        longint     ql, qr, qt, qb;
        int         hits[$];
        hit_word_t  hw;
        bit         live;
        int         i;
        live = (w.health > 0) && (w.is_active == 1'b1);
        ql = longint'(w.pos_x) + longint'(w.edge_left);
        qr = longint'(w.pos_x) + longint'(w.edge_right);
        qt = longint'(w.pos_y) + longint'(w.edge_top);
        qb = longint'(w.pos_y) + longint'(w.edge_bottom);
        case (w.func)
            bopf_pkg::FUNC_CLEAR: begin
                store_count = 0;
            end
            bopf_pkg::FUNC_APPEND: begin
                // Drop appends into a full list.
                if (store_count < bopf_pkg::LIST_DEPTH) begin
                    store_left[store_count]   = ql;
                    store_right[store_count]  = qr;
                    store_top[store_count]    = qt;
                    store_bottom[store_count] = qb;
                    store_live[store_count]   = live;
                    store_count++;
                end
            end
            bopf_pkg::FUNC_QUERY: begin
                if (live) begin
                    for (i = 0; i < store_count && hits.size() < bopf_pkg::MAX_RESULTS;
                         i++) begin
                        // Touching edges still count as overlap.
                        if (store_live[i] &&
                            !(ql > store_right[i] || qr < store_left[i] ||
                              qt > store_bottom[i] || qb < store_top[i]))
                            hits.push_back(i);
                    end
                end
                if (hits.size() == 0) begin
                    hw.hit_index = '0;
                    hw.hit_valid = 1'b0;
                    hw.last      = 1'b1;
                    expected_hits_q.push_back(hw);
                end else begin
                    foreach (hits[k]) begin
                        hw.hit_index = bopf_pkg::HIT_W'(hits[k]);
                        hw.hit_valid = 1'b1;
                        hw.last      = (k == hits.size() - 1);
                        expected_hits_q.push_back(hw);
                    end
                end
            end
            default: ;
        endcase
    endfunction

    function automatic box_word_t random_box(input logic [1:0] func, input bit near);
        box_word_t w;
        w.func = func;
        if (near) begin
            // Cluster boxes around the origin so that many of them overlap.
            w.pos_x       = int'($urandom_range(400)) - 200;
            w.pos_y       = int'($urandom_range(400)) - 200;
            w.edge_left   = 16'(int'($urandom_range(100)) - 80);
            w.edge_right  = 16'(int'($urandom_range(100)) - 20);
            w.edge_top    = 16'(int'($urandom_range(100)) - 80);
            w.edge_bottom = 16'(int'($urandom_range(100)) - 20);
        end else begin
            w.pos_x       = $urandom;
            w.pos_y       = $urandom;
            w.edge_left   = 16'($urandom);
            w.edge_right  = 16'($urandom);
            w.edge_top    = 16'($urandom);
            w.edge_bottom = 16'($urandom);
        end
        w.health    = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(32767, 1));
        w.is_active = ($urandom_range(9) != 0);
        return w;
    endfunction

    task automatic table_row(input logic [1:0] func,
                             input logic signed [31:0] px, input logic signed [31:0] py,
                             input logic signed [15:0] el, input logic signed [15:0] er,
                             input logic signed [15:0] et, input logic signed [15:0] eb,
                             input logic signed [15:0] hp, input logic act,
                             input check_kind_t kind,
                             input logic [bopf_pkg::HIT_W-1:0] gi, input logic gv,
                             input logic gl);
        stim_row_t row;
        row.w.func        = func;
        row.w.pos_x       = px;
        row.w.pos_y       = py;
        row.w.edge_left   = el;
        row.w.edge_right  = er;
        row.w.edge_top    = et;
        row.w.edge_bottom = eb;
        row.w.health      = hp;
        row.w.is_active   = act;
        row.kind          = kind;
        row.typed.hit_index = gi;
        row.typed.hit_valid = gv;
        row.typed.last      = gl;
        directed_rows.push_back(row);
    endtask

    // Present one word and hold it until accepted. Valid is lowered only when an idle
    // cycle is taken, so it never gets two assignments in one time step.
    task automatic send_word(input box_word_t w, input check_kind_t kind,
                             input hit_word_t typed);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_func        <= w.func;
        s_pos_x       <= w.pos_x;
        s_pos_y       <= w.pos_y;
        s_edge_left   <= w.edge_left;
        s_edge_right  <= w.edge_right;
        s_edge_top    <= w.edge_top;
        s_edge_bottom <= w.edge_bottom;
        s_health      <= w.health;
        s_is_active   <= w.is_active;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        // Accepted at this edge: typed rows are always single-result queries.
        if (kind == CHECK_TYPED && w.func == bopf_pkg::FUNC_QUERY)
            expected_hits_q.push_back(typed);
        else
            predict_overlaps(w);
    endtask

    // Receiver side: stall at random according to the current idle phase.
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Compare every accepted result word with the oldest prediction.
    always @(posedge aclk) begin : check_results
        hit_word_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_hits_q.size() == 0) begin
                $error("unexpected result word: hit_index %0d hit_valid %0d last %0d",
                       m_hit_index, m_hit_valid, m_last);
                error_count++;
            end else begin
                want = expected_hits_q.pop_front();
                if (m_hit_index !== want.hit_index) begin
                    $error("hit_index: expected %0d, actual %0d", want.hit_index, m_hit_index);
                    error_count++;
                end
                if (m_hit_valid !== want.hit_valid) begin
                    $error("hit_valid: expected %0d, actual %0d", want.hit_valid, m_hit_valid);
                    error_count++;
                end
                if (m_last !== want.last) begin
                    $error("last: expected %0d, actual %0d", want.last, m_last);
                    error_count++;
                end
            end
        end
    end

    // Watchdog: end the run if neither channel moves a word for too long.
    initial begin : watchdog
        int quiet;
        quiet = 0;
        wait (aresetn === 1'b1);
        while (quiet < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("DONE: errors detected");
        $finish;
    end

    initial begin : stimulus
        hit_word_t no_typed;
        box_word_t w;
        int        random_words;
        int        fill;
        int        queries;
        no_typed.hit_index = '0;
        no_typed.hit_valid = 1'b0;
        no_typed.last      = 1'b0;

        // Directed table. Typed rows carry their single result word.
        // Query on the empty list right after reset: one no-hit word.
        table_row(bopf_pkg::FUNC_QUERY,  0, 0, -10, 10, -10, 10, 1, 1, CHECK_TYPED, 0, 0, 1);
        table_row(bopf_pkg::FUNC_APPEND, 0, 0, -10, 10, -10, 10, 1, 1, CHECK_MODEL, 0, 0, 0);
        table_row(bopf_pkg::FUNC_QUERY,  0, 0, -10, 10, -10, 10, 5, 1, CHECK_TYPED, 0, 1, 1);
        // Touching right edge overlaps, one unit further does not.
        table_row(bopf_pkg::FUNC_QUERY,  20, 0, -10, 10, -10, 10, 5, 1, CHECK_TYPED, 0, 1, 1);
        table_row(bopf_pkg::FUNC_QUERY,  21, 0, -10, 10, -10, 10, 5, 1, CHECK_TYPED, 0, 0, 1);
        // Touching top edge.
        table_row(bopf_pkg::FUNC_QUERY,  0, -20, -10, 10, -10, 10, 5, 1, CHECK_TYPED, 0, 1, 1);
        // Query box not live: zero health, most negative health, inactive.
        table_row(bopf_pkg::FUNC_QUERY,  0, 0, -10, 10, -10, 10, 0, 1, CHECK_TYPED, 0, 0, 1);
        table_row(bopf_pkg::FUNC_QUERY,  0, 0, -10, 10, -10, 10, -32768, 1,
                  CHECK_TYPED, 0, 0, 1);
        table_row(bopf_pkg::FUNC_QUERY,  0, 0, -10, 10, -10, 10, 32767, 0,
                  CHECK_TYPED, 0, 0, 1);
        // Dead stored entries are skipped.
        table_row(bopf_pkg::FUNC_APPEND, 5, 5, -10, 10, -10, 10, 0, 1, CHECK_MODEL, 0, 0, 0);
        table_row(bopf_pkg::FUNC_APPEND, 5, 5, -10, 10, -10, 10, 32767, 0,
                  CHECK_MODEL, 0, 0, 0);
        table_row(bopf_pkg::FUNC_QUERY,  0, 0, -10, 10, -10, 10, 1, 1, CHECK_TYPED, 0, 1, 1);
        // Selector three with all-ones fields: ignored.
        table_row(FUNC_IGNORED, 32'hffff_ffff, 32'hffff_ffff, -1, -1, -1, -1, -1, 1,
                  CHECK_MODEL, 0, 0, 0);
        // Extreme positions and offsets: sums must not wrap.
        table_row(bopf_pkg::FUNC_APPEND, 32'h7fff_ffff, 32'h8000_0000,
                  -32768, 32767, -32768, 32767, 1, 1, CHECK_MODEL, 0, 0, 0);
        table_row(bopf_pkg::FUNC_QUERY,  32'h7fff_ffff, 32'h8000_0000,
                  32767, 32767, -32768, -32768, 1, 1, CHECK_TYPED, 3, 1, 1);
        table_row(bopf_pkg::FUNC_QUERY,  32'h8000_0000, 32'h7fff_ffff,
                  -32768, -32768, 32767, 32767, 1, 1, CHECK_TYPED, 0, 0, 1);
        // Inverted and maximal query boxes.
        table_row(bopf_pkg::FUNC_QUERY,  0, 0, 10, -10, 10, -10, 1, 1, CHECK_MODEL, 0, 0, 0);
        table_row(bopf_pkg::FUNC_QUERY,  0, 0, -32768, 32767, -32768, 32767, 1, 1,
                  CHECK_MODEL, 0, 0, 0);
        // Clear empties the list; indexes restart at zero.
        table_row(bopf_pkg::FUNC_CLEAR,  0, 0, 0, 0, 0, 0, 0, 0, CHECK_MODEL, 0, 0, 0);
        table_row(bopf_pkg::FUNC_QUERY,  0, 0, -10, 10, -10, 10, 1, 1, CHECK_TYPED, 0, 0, 1);
        table_row(bopf_pkg::FUNC_APPEND, 0, 0, -10, 10, -10, 10, 1, 1, CHECK_MODEL, 0, 0, 0);
        table_row(bopf_pkg::FUNC_QUERY,  0, 0, -10, 10, -10, 10, 1, 1, CHECK_TYPED, 0, 1, 1);
        table_row(bopf_pkg::FUNC_APPEND, 3, 3, -10, 10, -10, 10, 1, 1, CHECK_MODEL, 0, 0, 0);
        table_row(bopf_pkg::FUNC_QUERY,  0, 0, -10, 10, -10, 10, 1, 1, CHECK_MODEL, 0, 0, 0);
        // Clear with garbage in the ignored fields.
        table_row(bopf_pkg::FUNC_CLEAR,  32'h8000_0000, 32'h7fff_ffff,
                  -32768, 32767, 32767, -32768, -32768, 1, CHECK_MODEL, 0, 0, 0);

        // Hold reset, then release it once.
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_rows[r])
            send_word(directed_rows[r].w, directed_rows[r].kind, directed_rows[r].typed);

        // Random part: mostly well-formed load-then-query sequences, some noise words.
        random_words = 0;
        while (random_words < RANDOM_WORDS) begin
            // Swap the idle phases by thirds, and finish without any idling.
            if (random_words < RANDOM_WORDS / 3) begin
                send_idle_pct = 23;
                recv_idle_pct = 47;
            end else if (random_words < 2 * RANDOM_WORDS / 3) begin
                send_idle_pct = 47;
                recv_idle_pct = 23;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            if ($urandom_range(99) < 85) begin
                send_word(random_box(bopf_pkg::FUNC_CLEAR, $urandom_range(1) != 0),
                          CHECK_MODEL, no_typed);
                // Now and then overfill the list so appends get dropped.
                fill = ($urandom_range(9) < 3) ? $urandom_range(18, 16) : $urandom_range(15);
                queries = $urandom_range(5, 1);
                repeat (fill)
                    send_word(random_box(bopf_pkg::FUNC_APPEND, $urandom_range(4) != 0),
                              CHECK_MODEL, no_typed);
                repeat (queries)
                    send_word(random_box(bopf_pkg::FUNC_QUERY, $urandom_range(4) != 0),
                              CHECK_MODEL, no_typed);
                random_words += 1 + fill + queries;
            end else begin
                w = random_box(2'($urandom_range(3)), $urandom_range(1) != 0);
                send_word(w, CHECK_MODEL, no_typed);
                if (w.func != FUNC_IGNORED)
                    random_words++;
            end
        end
        s_valid <= 1'b0;

        // Drain: wait for every predicted word, then watch for strays.
        while (expected_hits_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (expected_hits_q.size() != 0) begin
            $error("%0d predicted result words never arrived", expected_hits_q.size());
            error_count++;
        end

        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
